[rtl/core/qvr_pkg.sv]
// package with default widths for the quaternion vector rotation block
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int VEC_WIDTH_DEFAULT  = 32;
    localparam int QUAT_WIDTH_DEFAULT = 16;
    localparam int NUM_AXES           = 3;

endpackage : qvr_pkg

[rtl/core/quaternion_vector_rotation.sv]
// quaternion vector rotation, pipelined, one transfer per clock
`timescale 1ns / 1ps

// Rotates a Q16.16 vector by a Q2.14 quaternion: out = q * (0, v) * conj(q), taken
// at full precision, then rounded half up by 2*(QUAT_WIDTH-2) bits and saturated.
// A quaternion that is not of unit length scales the result by |q|^2.
// A new item can be started in every clock cycle; o_busy is always low. The result
// appears on the o_rot_* ports with o_valid high for exactly one cycle, after the
// item has passed through the seven register stages, which are, in order:
// input capture, quaternion products, rotation matrix, split matrix-by-vector
// products, per-axis sums, recombine and round, shift and saturate. The receiver
// cannot stall the block and must take each result in the cycle it is shown.
module quaternion_vector_rotation #(
    parameter int VECTOR_WIDTH = qvr_pkg::VEC_WIDTH_DEFAULT,
    parameter int QUAT_WIDTH   = qvr_pkg::QUAT_WIDTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [QUAT_WIDTH-1:0]   i_quat_w,
    input  logic signed [QUAT_WIDTH-1:0]   i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]   i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]   i_quat_z,
    input  logic signed [VECTOR_WIDTH-1:0] i_vec_x,
    input  logic signed [VECTOR_WIDTH-1:0] i_vec_y,
    input  logic signed [VECTOR_WIDTH-1:0] i_vec_z,
    output logic                           o_valid,
    output logic signed [VECTOR_WIDTH-1:0] o_rot_x,
    output logic signed [VECTOR_WIDTH-1:0] o_rot_y,
    output logic signed [VECTOR_WIDTH-1:0] o_rot_z,
    output logic                           o_saturated
);
    import qvr_pkg::*;

    localparam int QW     = QUAT_WIDTH;
    localparam int VW     = VECTOR_WIDTH;
    localparam int PW     = 2 * QW;
    localparam int MW     = 2 * QW + 2;
    localparam int VL     = VW / 2;
    localparam int VH     = VW - VL;
    localparam int PLW    = MW + VL + 1;
    localparam int PHW    = MW + VH;
    localparam int SLW    = PLW + 2;
    localparam int SHW    = PHW + 2;
    localparam int SW     = MW + VW + 3;
    localparam int SHIFT  = 2 * (QW - 2);
    localparam int TW     = SW - SHIFT;
    localparam int STAGES = 7;

    localparam logic signed [SW-1:0] HALF =
        {{(SW - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};

    logic [STAGES-1:0] r_vld;

    // stage 1: capture
    logic signed [QW-1:0] r_s1_w, r_s1_x, r_s1_y, r_s1_z;
    logic signed [VW-1:0] r_s1_v [NUM_AXES];

    // stage 2: quaternion products
    logic signed [PW-1:0] r_s2_ww, r_s2_xx, r_s2_yy, r_s2_zz;
    logic signed [PW-1:0] r_s2_xy, r_s2_xz, r_s2_yz;
    logic signed [PW-1:0] r_s2_wx, r_s2_wy, r_s2_wz;
    logic signed [VW-1:0] r_s2_v [NUM_AXES];

    // stage 3: rotation matrix
    logic signed [MW-1:0] r_s3_m [NUM_AXES][NUM_AXES];
    logic signed [VW-1:0] r_s3_v [NUM_AXES];

    // stage 4: partial products
    logic signed [PLW-1:0] r_s4_pl [NUM_AXES][NUM_AXES];
    logic signed [PHW-1:0] r_s4_ph [NUM_AXES][NUM_AXES];

    // stage 5: per-axis sums of partial products
    logic signed [SLW-1:0] r_s5_sl [NUM_AXES];
    logic signed [SHW-1:0] r_s5_sh [NUM_AXES];

    // stage 6: recombined and rounded sums
    logic signed [SW-1:0] r_s6_s [NUM_AXES];

    // stage 7: outputs
    logic signed [VW-1:0] r_rot [NUM_AXES];
    logic                 r_sat;

    logic signed [TW-1:0] n_t    [NUM_AXES];
    logic signed [VW-1:0] n_rot  [NUM_AXES];
    logic [NUM_AXES-1:0]  n_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_w    <= i_quat_w;
        r_s1_x    <= i_quat_x;
        r_s1_y    <= i_quat_y;
        r_s1_z    <= i_quat_z;
        r_s1_v[0] <= i_vec_x;
        r_s1_v[1] <= i_vec_y;
        r_s1_v[2] <= i_vec_z;
    end

    always_ff @(posedge i_clk) begin
        r_s2_ww <= r_s1_w * r_s1_w;
        r_s2_xx <= r_s1_x * r_s1_x;
        r_s2_yy <= r_s1_y * r_s1_y;
        r_s2_zz <= r_s1_z * r_s1_z;
        r_s2_xy <= r_s1_x * r_s1_y;
        r_s2_xz <= r_s1_x * r_s1_z;
        r_s2_yz <= r_s1_y * r_s1_z;
        r_s2_wx <= r_s1_w * r_s1_x;
        r_s2_wy <= r_s1_w * r_s1_y;
        r_s2_wz <= r_s1_w * r_s1_z;
        r_s2_v  <= r_s1_v;
    end

    always_ff @(posedge i_clk) begin
        r_s3_m[0][0] <= MW'(r_s2_ww) + MW'(r_s2_xx) - MW'(r_s2_yy) - MW'(r_s2_zz);
        r_s3_m[0][1] <= (MW'(r_s2_xy) - MW'(r_s2_wz)) <<< 1;
        r_s3_m[0][2] <= (MW'(r_s2_xz) + MW'(r_s2_wy)) <<< 1;
        r_s3_m[1][0] <= (MW'(r_s2_xy) + MW'(r_s2_wz)) <<< 1;
        r_s3_m[1][1] <= MW'(r_s2_ww) - MW'(r_s2_xx) + MW'(r_s2_yy) - MW'(r_s2_zz);
        r_s3_m[1][2] <= (MW'(r_s2_yz) - MW'(r_s2_wx)) <<< 1;
        r_s3_m[2][0] <= (MW'(r_s2_xz) - MW'(r_s2_wy)) <<< 1;
        r_s3_m[2][1] <= (MW'(r_s2_yz) + MW'(r_s2_wx)) <<< 1;
        r_s3_m[2][2] <= MW'(r_s2_ww) - MW'(r_s2_xx) - MW'(r_s2_yy) + MW'(r_s2_zz);
        r_s3_v       <= r_s2_v;
    end

    // vector split into an unsigned low half and a signed high half
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_AXES; i++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                r_s4_pl[i][j] <= r_s3_m[i][j] * $signed({1'b0, r_s3_v[j][VL-1:0]});
                r_s4_ph[i][j] <= r_s3_m[i][j] * $signed(r_s3_v[j][VW-1:VL]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_AXES; i++) begin
            r_s5_sl[i] <= SLW'(r_s4_pl[i][0]) + SLW'(r_s4_pl[i][1]) + SLW'(r_s4_pl[i][2]);
            r_s5_sh[i] <= SHW'(r_s4_ph[i][0]) + SHW'(r_s4_ph[i][1]) + SHW'(r_s4_ph[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_AXES; i++) begin
            r_s6_s[i] <= (SW'(r_s5_sh[i]) <<< VL) + SW'(r_s5_sl[i]) + HALF;
        end
    end

    // shift down and saturate
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            n_t[i] = TW'(r_s6_s[i] >>> SHIFT);
            if ((&n_t[i][TW-1:VW-1]) || !(|n_t[i][TW-1:VW-1])) begin
                n_clip[i] = 1'b0;
                n_rot[i]  = n_t[i][VW-1:0];
            end else begin
                n_clip[i] = 1'b1;
                n_rot[i]  = n_t[i][TW-1] ? {1'b1, {(VW - 1){1'b0}}}
                                         : {1'b0, {(VW - 1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
        r_sat <= |n_clip;
    end

    assign o_busy      = 1'b0;
    assign o_valid     = r_vld[STAGES-1];
    assign o_rot_x     = r_rot[0];
    assign o_rot_y     = r_rot[1];
    assign o_rot_z     = r_rot[2];
    assign o_saturated = r_sat;

endmodule : quaternion_vector_rotation

[test/qvr_rotation_checker.sv]
// checker that predicts each rotated vector and compares it with the block output
`timescale 1ns / 1ps

module qvr_rotation_checker #(
    parameter int VECTOR_WIDTH = qvr_pkg::VEC_WIDTH_DEFAULT,
    parameter int QUAT_WIDTH   = qvr_pkg::QUAT_WIDTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic signed [QUAT_WIDTH-1:0]   i_quat_w,
    input  logic signed [QUAT_WIDTH-1:0]   i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0]   i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0]   i_quat_z,
    input  logic signed [VECTOR_WIDTH-1:0] i_vec_x,
    input  logic signed [VECTOR_WIDTH-1:0] i_vec_y,
    input  logic signed [VECTOR_WIDTH-1:0] i_vec_z,
    input  logic                           i_valid,
    input  logic signed [VECTOR_WIDTH-1:0] i_rot_x,
    input  logic signed [VECTOR_WIDTH-1:0] i_rot_y,
    input  logic signed [VECTOR_WIDTH-1:0] i_rot_z,
    input  logic                           i_saturated,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    localparam int ROUND_SHIFT = 2 * (QUAT_WIDTH - 2);
    localparam logic signed [127:0] ROT_MAX    = (128'sd1 <<< (VECTOR_WIDTH - 1)) - 128'sd1;
    localparam logic signed [127:0] ROT_MIN    = -(128'sd1 <<< (VECTOR_WIDTH - 1));
    localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (ROUND_SHIFT - 1);

    typedef struct {
        logic signed [VECTOR_WIDTH-1:0] x;
        logic signed [VECTOR_WIDTH-1:0] y;
        logic signed [VECTOR_WIDTH-1:0] z;
        logic                           sat;
    } t_rotated_vec;

    t_rotated_vec expected_rotations[$];
    int           mismatch_count = 0;

    // one row of the rotation matrix times the vector, top bit is the clip flag
    function automatic logic [VECTOR_WIDTH:0] apply_row(input longint m0, m1, m2,
                                                        input longint v0, v1, v2);
        logic signed [127:0] a0, a1, a2, b0, b1, b2, acc;
        a0 = m0;
        a1 = m1;
        a2 = m2;
        b0 = v0;
        b1 = v1;
        b2 = v2;
        acc = (a0 * b0 + a1 * b1 + a2 * b2 + ROUND_HALF) >>> ROUND_SHIFT;
        if (acc > ROT_MAX) return {1'b1, ROT_MAX[VECTOR_WIDTH-1:0]};
        if (acc < ROT_MIN) return {1'b1, ROT_MIN[VECTOR_WIDTH-1:0]};
        return {1'b0, acc[VECTOR_WIDTH-1:0]};
    endfunction

    function automatic t_rotated_vec rotate_vector(
        input logic signed [QUAT_WIDTH-1:0]   qw, qx, qy, qz,
        input logic signed [VECTOR_WIDTH-1:0] px, py, pz
    );
        longint w, x, y, z, vx, vy, vz;
        longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        logic [VECTOR_WIDTH:0] rx, ry, rz;
        t_rotated_vec r;
        w  = qw;
        x  = qx;
        y  = qy;
        z  = qz;
        vx = px;
        vy = py;
        vz = pz;
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        wx = w * x;
        wy = w * y;
        wz = w * z;
        rx = apply_row(ww + xx - yy - zz, 2 * (xy - wz), 2 * (xz + wy), vx, vy, vz);
        ry = apply_row(2 * (xy + wz), ww - xx + yy - zz, 2 * (yz - wx), vx, vy, vz);
        rz = apply_row(2 * (xz - wy), 2 * (yz + wx), ww - xx - yy + zz, vx, vy, vz);
        r.x   = rx[VECTOR_WIDTH-1:0];
        r.y   = ry[VECTOR_WIDTH-1:0];
        r.z   = rz[VECTOR_WIDTH-1:0];
        r.sat = rx[VECTOR_WIDTH] | ry[VECTOR_WIDTH] | rz[VECTOR_WIDTH];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rotated_vec want;
        if (i_rst_n) begin
            // result first so an item accepted on this edge is never matched to it
            if (i_valid) begin
                if (expected_rotations.size() == 0) begin
                    $error("result transfer with nothing expected: x=%0d y=%0d z=%0d",
                           i_rot_x, i_rot_y, i_rot_z);
                    mismatch_count++;
                end else begin
                    want = expected_rotations[0];
                    expected_rotations.delete(0);
                    if (i_rot_x !== want.x) begin
                        $error("rot_x: expected %0d, actual %0d", want.x, i_rot_x);
                        mismatch_count++;
                    end
                    if (i_rot_y !== want.y) begin
                        $error("rot_y: expected %0d, actual %0d", want.y, i_rot_y);
                        mismatch_count++;
                    end
                    if (i_rot_z !== want.z) begin
                        $error("rot_z: expected %0d, actual %0d", want.z, i_rot_z);
                        mismatch_count++;
                    end
                    if (i_saturated !== want.sat) begin
                        $error("saturated: expected %0b, actual %0b", want.sat, i_saturated);
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_rotations.insert(expected_rotations.size(),
                                          rotate_vector(i_quat_w, i_quat_x, i_quat_y,
                                                        i_quat_z, i_vec_x, i_vec_y,
                                                        i_vec_z));
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_rotations.size();
    end

endmodule

[test/tb_quaternion_vector_rotation.sv]
// testbench top for the quaternion vector rotation block
`timescale 1ns / 1ps

module tb_quaternion_vector_rotation;

    localparam int VW         = qvr_pkg::VEC_WIDTH_DEFAULT;
    localparam int QW         = qvr_pkg::QUAT_WIDTH_DEFAULT;
    localparam int ITEM_COUNT = 1750;

    localparam logic signed [QW-1:0] Q_ONE  = QW'(1 << (QW - 2));
    localparam logic signed [QW-1:0] Q_HALF = QW'(11585);
    localparam logic signed [QW-1:0] Q_MAX  = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN  = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [VW-1:0] V_MAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN  = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] V_ONE  = VW'(1 << 16);
    localparam logic signed [VW-1:0] V_HALF_LSB = VW'(1 << 27);

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic signed [QW-1:0] i_quat_w = '0;
    logic signed [QW-1:0] i_quat_x = '0;
    logic signed [QW-1:0] i_quat_y = '0;
    logic signed [QW-1:0] i_quat_z = '0;
    logic signed [VW-1:0] i_vec_x  = '0;
    logic signed [VW-1:0] i_vec_y  = '0;
    logic signed [VW-1:0] i_vec_z  = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic signed [VW-1:0] o_rot_x;
    logic signed [VW-1:0] o_rot_y;
    logic signed [VW-1:0] o_rot_z;
    logic                 o_saturated;
    int                   mismatches;
    int                   outstanding;
    bit                   no_gaps = 1'b0;

    always #10 i_clk = ~i_clk;

    quaternion_vector_rotation #(
        .VECTOR_WIDTH (VW),
        .QUAT_WIDTH   (QW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_quat_w    (i_quat_w),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .o_valid     (o_valid),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y),
        .o_rot_z     (o_rot_z),
        .o_saturated (o_saturated)
    );

    qvr_rotation_checker #(
        .VECTOR_WIDTH (VW),
        .QUAT_WIDTH   (QW)
    ) rotation_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_quat_w      (i_quat_w),
        .i_quat_x      (i_quat_x),
        .i_quat_y      (i_quat_y),
        .i_quat_z      (i_quat_z),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_vec_z       (i_vec_z),
        .i_valid       (o_valid),
        .i_rot_x       (o_rot_x),
        .i_rot_y       (o_rot_y),
        .i_rot_z       (o_rot_z),
        .i_saturated   (o_saturated),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_rotation(input logic signed [QW-1:0] w, x, y, z,
                                 input logic signed [VW-1:0] vx, vy, vz);
        if (!no_gaps) begin
            while ($urandom_range(99) < 21) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start  <= 1'b1;
        i_quat_w <= w;
        i_quat_x <= x;
        i_quat_y <= y;
        i_quat_z <= z;
        i_vec_x  <= vx;
        i_vec_y  <= vy;
        i_vec_z  <= vz;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain_rotations(input int max_cycles);
        i_start <= 1'b0;
        @(posedge i_clk);
        for (int k = 0; k < max_cycles && outstanding != 0; k++) @(posedge i_clk);
    endtask

    // full range, roughly unit length, or a notable value
    function automatic logic signed [QW-1:0] pick_quat_part(input int style);
        if (style < 4) return QW'($urandom);
        if (style < 8) return QW'(int'($urandom_range(23170)) - 11585);
        case ($urandom_range(6))
            0: return '0;
            1: return Q_ONE;
            2: return -Q_ONE;
            3: return Q_MAX;
            4: return Q_MIN;
            5: return Q_HALF;
            default: return QW'($urandom);
        endcase
    endfunction

    function automatic logic signed [VW-1:0] pick_vec_part(input int style);
        if (style < 4) return VW'($urandom);
        if (style < 8) return VW'(int'($urandom_range(1 << 22)) - (1 << 21));
        case ($urandom_range(5))
            0: return '0;
            1: return V_MAX;
            2: return V_MIN;
            3: return '1;
            4: return V_HALF_LSB;
            default: return VW'($urandom);
        endcase
    endfunction

    initial begin
        int qs, vs;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity, negated identity and zero quaternion
        send_rotation(Q_ONE, 0, 0, 0, V_ONE, -2 * V_ONE, 3 * V_ONE);
        send_rotation(Q_ONE, 0, 0, 0, V_MAX, V_MIN, 0);
        send_rotation(-Q_ONE, 0, 0, 0, V_MIN, V_MAX, -1);
        send_rotation(Q_ONE, 0, 0, 0, -1, -1, -1);
        send_rotation(0, 0, 0, 0, V_MAX, V_MIN, V_MAX);
        // quarter and half turns about each axis
        send_rotation(Q_HALF, Q_HALF, 0, 0, 0, V_ONE, 0);
        send_rotation(Q_HALF, 0, Q_HALF, 0, 0, 0, V_ONE);
        send_rotation(Q_HALF, 0, 0, Q_HALF, V_ONE, 0, 0);
        send_rotation(0, Q_ONE, 0, 0, 1, 2, 3);
        send_rotation(0, 0, Q_ONE, 0, V_MAX, V_MAX, V_MAX);
        send_rotation(0, 0, 0, Q_ONE, V_MIN, V_MIN, V_MIN);
        // non-unit quaternions and overflow
        send_rotation(Q_MAX, 0, 0, 0, V_ONE, -V_ONE, 12345);
        send_rotation(Q_MIN, 0, 0, 0, 1, -1, V_MAX);
        send_rotation(Q_MIN, Q_MIN, Q_MIN, Q_MIN, V_MAX, V_MAX, V_MAX);
        send_rotation(Q_MIN, Q_MIN, Q_MIN, Q_MIN, V_MIN, V_MAX, V_MIN);
        send_rotation(Q_MAX, Q_MAX, Q_MAX, Q_MAX, V_MIN, V_MIN, V_MAX);
        send_rotation(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 12345678, -87654321, 1);
        send_rotation(-1, -1, -1, -1, V_MAX, V_MIN, V_MAX);
        // rounding exactly at and around one half
        send_rotation(1, 0, 0, 0, V_HALF_LSB, -V_HALF_LSB, V_HALF_LSB - 1);
        send_rotation(1, 0, 0, 0, 3 * V_HALF_LSB, -3 * V_HALF_LSB, -V_HALF_LSB - 1);

        // hold off until the pipeline is empty
        drain_rotations(1000);

        for (int i = 0; i < ITEM_COUNT; i++) begin
            no_gaps = (i >= 700 && i < 1000);
            if (i == 1300) drain_rotations(1000);
            qs = $urandom_range(9);
            vs = $urandom_range(9);
            send_rotation(pick_quat_part(qs), pick_quat_part(qs), pick_quat_part(qs),
                          pick_quat_part(qs), pick_vec_part(vs), pick_vec_part(vs),
                          pick_vec_part(vs));
        end

        drain_rotations(1000);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            if (outstanding != 0) $error("%0d expected rotations never came out", outstanding);
            $display("FAIL");
        end
        $finish;
    end

endmodule
